// File: hw/rtl/ulc_pkg.sv
// ----------------------------------------------------------------------------
// ulc_pkg
// Shared types, constants and the ones' complement adder for the IPv6
// upper-layer checksum unit.
// ----------------------------------------------------------------------------
package ulc_pkg;

    localparam int LINK_HEADER_BYTES_DEF = 14;
    localparam int MAX_FRAME_BYTES_DEF   = 2048;
    localparam int IP_HEADER_BYTES       = 40;
    localparam int QUEUE_DEPTH           = 2;
    localparam int QUEUE_PTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] SUM_ALL_ONES = 16'hffff;

    typedef enum logic [1:0] {
        OP_SKIP = 2'd0,
        OP_SEED = 2'd1,
        OP_WORD = 2'd2
    } byte_op_t;

    // One classified byte, as handed from the front part to the back part
    typedef struct packed {
        byte_op_t    op;
        logic [7:0]  data;
        logic [15:0] seed_len;
        logic        last;
        logic        short_frame;
    } queue_entry_t;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

endpackage

// File: hw/rtl/ulc_front.sv
// ----------------------------------------------------------------------------
// ulc_front
// Byte classifier: tracks frame position, picks up the payload length and
// tags each byte for the summing stage.
// ----------------------------------------------------------------------------
module ulc_front #(
    parameter int LINK_HEADER_BYTES = ulc_pkg::LINK_HEADER_BYTES_DEF,
    parameter int MAX_FRAME_BYTES   = ulc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            frame_byte,
    input  logic                  end_of_frame,
    output ulc_pkg::queue_entry_t entry
);

    localparam int POS_W         = $clog2(MAX_FRAME_BYTES);
    localparam int PAYLOAD_START = LINK_HEADER_BYTES + ulc_pkg::IP_HEADER_BYTES;

    localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(LINK_HEADER_BYTES + 4);
    localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(LINK_HEADER_BYTES + 5);
    localparam logic [POS_W-1:0] POS_NXT_HDR = POS_W'(LINK_HEADER_BYTES + 6);
    localparam logic [POS_W-1:0] POS_ADDR    = POS_W'(LINK_HEADER_BYTES + 8);
    localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(PAYLOAD_START);
    localparam logic [POS_W-1:0] POS_HDR_END = POS_W'(PAYLOAD_START - 1);
    localparam logic [POS_W-1:0] POS_SAT     = POS_W'(MAX_FRAME_BYTES - 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      len_reg, len_next;
    logic [15:0]      rem_reg, rem_next;

    always_comb begin
        len_next       = len_reg;
        rem_next       = rem_reg;
        entry.op       = ulc_pkg::OP_SKIP;
        entry.data     = frame_byte;
        entry.seed_len = len_reg;
        entry.last     = end_of_frame;

        if (pos_reg == POS_LEN_HI) begin
            len_next = {frame_byte, 8'h00};
        end else if (pos_reg == POS_LEN_LO) begin
            len_next = {len_reg[15:8], frame_byte};
            rem_next = {len_reg[15:8], frame_byte};
        end else if (pos_reg == POS_NXT_HDR) begin
            entry.op = ulc_pkg::OP_SEED;
        end else if (pos_reg >= POS_ADDR && pos_reg < POS_PAYLOAD) begin
            entry.op = ulc_pkg::OP_WORD;
        end else if (pos_reg >= POS_PAYLOAD && rem_reg != 16'd0) begin
            entry.op = ulc_pkg::OP_WORD;
            rem_next = rem_reg - 16'd1;
        end

        entry.short_frame = (pos_reg < POS_HDR_END) || (rem_next != 16'd0);

        pos_next = (pos_reg < POS_SAT) ? pos_reg + POS_W'(1) : pos_reg;

        // a frame end starts the next frame from scratch
        if (end_of_frame) begin
            pos_next = '0;
            len_next = '0;
            rem_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            len_reg <= '0;
            rem_reg <= '0;
        end else if (accept) begin
            pos_reg <= pos_next;
            len_reg <= len_next;
            rem_reg <= rem_next;
        end
    end

endmodule

// File: hw/rtl/ulc_queue.sv
// ----------------------------------------------------------------------------
// ulc_queue
// Short FIFO of classified bytes between the classifier and the summer.
// ----------------------------------------------------------------------------
module ulc_queue (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                push,
    input  ulc_pkg::queue_entry_t               push_entry,
    output logic                                full,
    input  logic                                pop,
    output logic                                not_empty,
    output ulc_pkg::queue_entry_t               head,
    output logic [ulc_pkg::QUEUE_CNT_W-1:0]     count
);

    ulc_pkg::queue_entry_t                 slot_reg [ulc_pkg::QUEUE_DEPTH];
    logic [ulc_pkg::QUEUE_PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [ulc_pkg::QUEUE_CNT_W-1:0]       count_reg, count_next;

    localparam logic [ulc_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        ulc_pkg::QUEUE_PTR_W'(ulc_pkg::QUEUE_DEPTH - 1);

    assign full      = (count_reg == ulc_pkg::QUEUE_CNT_W'(ulc_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + ulc_pkg::QUEUE_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - ulc_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/ulc_back.sv
// ----------------------------------------------------------------------------
// ulc_back
// Summer: one ones' complement add per byte, result register on the output.
// ----------------------------------------------------------------------------
module ulc_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  ulc_pkg::queue_entry_t q_head,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [15:0]           m_checksum_sum,
    output logic                  m_short_frame
);

    logic [15:0] sum_reg, sum_next;
    logic [7:0]  pend_reg, pend_next;
    logic        wait_reg, wait_next;
    logic        m_valid_reg;
    logic [15:0] res_sum_reg;
    logic        res_short_reg;

    logic [15:0] add_a, add_b, add_out, final_sum;
    logic        is_word;

    // a frame end can only leave once the result slot is free
    assign pop = q_valid && (!q_head.last || !m_valid_reg || m_ready);

    always_comb begin
        is_word   = (q_head.op == ulc_pkg::OP_WORD);
        add_a     = sum_reg;
        add_b     = 16'h0000;
        pend_next = pend_reg;
        wait_next = wait_reg;

        case (q_head.op)
            ulc_pkg::OP_SEED: begin
                add_a = q_head.seed_len;
                add_b = {8'h00, q_head.data};
            end
            ulc_pkg::OP_WORD: begin
                if (wait_reg) begin
                    add_b     = {pend_reg, q_head.data};
                    wait_next = 1'b0;
                end else begin
                    pend_next = q_head.data;
                    wait_next = 1'b1;
                    // odd byte at frame end: pad with a zero low byte
                    if (q_head.last) begin
                        add_b = {q_head.data, 8'h00};
                    end
                end
            end
            default: begin
                if (q_head.last && wait_reg) begin
                    add_b = {pend_reg, 8'h00};
                end
            end
        endcase

        add_out   = ulc_pkg::oc_add(add_a, add_b);
        final_sum = (add_out == 16'h0000) ? ulc_pkg::SUM_ALL_ONES : add_out;

        // keep a padded odd byte out of the running sum until its partner
        sum_next = (is_word && !wait_reg) ? sum_reg : add_out;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            pend_reg    <= '0;
            wait_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop && q_head.last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (pop) begin
                if (q_head.last) begin
                    sum_reg  <= '0;
                    pend_reg <= '0;
                    wait_reg <= 1'b0;
                end else begin
                    sum_reg  <= sum_next;
                    pend_reg <= pend_next;
                    wait_reg <= wait_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && q_head.last) begin
            res_sum_reg   <= final_sum;
            res_short_reg <= q_head.short_frame;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_checksum_sum = res_sum_reg;
    assign m_short_frame  = res_short_reg;

endmodule

// File: hw/rtl/ipv6_upper_layer_checksum_unit.sv
// ----------------------------------------------------------------------------
// ipv6_upper_layer_checksum_unit
// Takes an Ethernet frame one byte per transfer, from the destination MAC
// onwards, and returns one result per frame on the byte flagged as the end:
// the folded, uncomplemented ones' complement sum of the IPv6 pseudo-header
// (length plus next header, source and destination addresses) and exactly
// payload-length bytes after the IPv6 header, zero reported as 0xFFFF, with
// a flag if the frame ended early. The unit takes one byte per clock while
// s_ready is high; each byte costs one 16-bit end-around-carry add in the
// summer. A two-entry queue between classifier and summer and the result
// register let input keep flowing while a result waits; a frame end stalls
// only when the previous result has not yet been taken. The last byte is
// queued, then summed into the result register that drives the outputs.
// ----------------------------------------------------------------------------
module ipv6_upper_layer_checksum_unit #(
    parameter int LINK_HEADER_BYTES = ulc_pkg::LINK_HEADER_BYTES_DEF,
    parameter int MAX_FRAME_BYTES   = ulc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_frame_byte,
    input  logic        s_end_of_frame,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_checksum_sum,
    output logic        m_short_frame
);

    ulc_pkg::queue_entry_t               front_entry;
    ulc_pkg::queue_entry_t               q_head;
    logic                                q_full;
    logic                                q_valid;
    logic                                q_pop;
    logic [ulc_pkg::QUEUE_CNT_W-1:0]     q_count;
    logic                                s_accept;

    assign s_ready  = !q_full;
    assign s_accept = s_valid && s_ready;

    ulc_front #(
        .LINK_HEADER_BYTES (LINK_HEADER_BYTES),
        .MAX_FRAME_BYTES   (MAX_FRAME_BYTES)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_accept),
        .frame_byte   (s_frame_byte),
        .end_of_frame (s_end_of_frame),
        .entry        (front_entry)
    );

    ulc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_accept),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .head       (q_head),
        .count      (q_count)
    );

    ulc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_head         (q_head),
        .pop            (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_checksum_sum (m_checksum_sum),
        .m_short_frame  (m_short_frame)
    );

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= ulc_pkg::QUEUE_CNT_W'(ulc_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_result_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_checksum_sum != 16'h0000))
        else $error("zero checksum presented");

    a_result_from_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(q_pop && q_head.last))
        else $error("result without a frame end leaving the queue");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_count != '0)
        else $error("pop from empty queue");

endmodule

// File: dv/tb_ipv6_upper_layer_checksum_unit.sv
// ----------------------------------------------------------------------------
// tb_ipv6_upper_layer_checksum_unit
// Streams Ethernet frames carrying IPv6 packets into the checksum unit one
// byte per transfer and compares every returned sum and short-frame flag
// against a cycle-independent prediction built from the accepted bytes.
// Covers runt and truncated frames, odd payloads, trailing bytes, position
// saturation on oversize frames, long result back-pressure and random
// traffic, with bursty input and an irregular result consumer.
// ----------------------------------------------------------------------------
module tb_ipv6_upper_layer_checksum_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IP_OFF       = ulc_pkg::LINK_HEADER_BYTES_DEF;
    localparam int PAY_OFF      = IP_OFF + ulc_pkg::IP_HEADER_BYTES;
    localparam int MAX_POS      = ulc_pkg::MAX_FRAME_BYTES_DEF - 1;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
    typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_MOSTLY, RDY_PATTERN} ready_mode_t;

    typedef struct packed {
        logic [15:0] sum;
        logic        is_short;
    } csum_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_frame_byte;
    logic        s_end_of_frame;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_checksum_sum;
    logic        m_short_frame;

    // predictor state
    logic [10:0] frame_pos;
    logic [15:0] acc_sum;
    logic [15:0] pay_len;
    logic [15:0] pay_left;
    logic [7:0]  held_hi;
    logic        hi_held;

    csum_result_t expected_sums[$];
    logic [7:0]   frame_buf[$];

    int  n_errors        = 0;
    int  n_bytes_sent    = 0;
    int  n_frames        = 0;
    int  n_results       = 0;
    int  n_short_results = 0;
    int  n_input_stalls  = 0;
    int  burst_left      = 0;
    bit  gaps_enabled    = 1'b0;
    int  hold_off_request = 0;

    ipv6_upper_layer_checksum_unit #(
        .LINK_HEADER_BYTES(ulc_pkg::LINK_HEADER_BYTES_DEF),
        .MAX_FRAME_BYTES  (ulc_pkg::MAX_FRAME_BYTES_DEF)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_frame_byte  (s_frame_byte),
        .s_end_of_frame(s_end_of_frame),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_checksum_sum(m_checksum_sum),
        .m_short_frame (m_short_frame)
    );

    always #5ns aclk = ~aclk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [15:0] ones_add(input logic [15:0] x, input logic [15:0] y);
        int t;
        t = int'(x) + int'(y);
        if (t > 32'h0000_ffff)
            t = t - 32'h0000_ffff;
        return t[15:0];
    endfunction

    function automatic void clear_frame_state();
        frame_pos = '0;
        acc_sum   = '0;
        pay_len   = '0;
        pay_left  = '0;
        held_hi   = '0;
        hi_held   = 1'b0;
    endfunction

    function automatic void absorb_word_byte(input logic [7:0] value);
        if (hi_held) begin
            acc_sum = ones_add(acc_sum, {held_hi, value});
            hi_held = 1'b0;
        end else begin
            held_hi = value;
            hi_held = 1'b1;
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] value, input logic last);
        int           p;
        csum_result_t res;
        p = int'(frame_pos);
        if (p == IP_OFF + 4) begin
            pay_len = {value, 8'h00};
        end else if (p == IP_OFF + 5) begin
            pay_len  = {pay_len[15:8], value};
            pay_left = pay_len;
        end else if (p == IP_OFF + 6) begin
            acc_sum = ones_add(pay_len, {8'h00, value});
        end else if (p >= IP_OFF + 8 && p < PAY_OFF) begin
            absorb_word_byte(value);
        end else if (p >= PAY_OFF && pay_left != 0) begin
            absorb_word_byte(value);
            pay_left = pay_left - 16'd1;
        end
        if (p < MAX_POS)
            frame_pos = frame_pos + 11'd1;
        if (last) begin
            res.is_short = (p + 1 < PAY_OFF) || (pay_left != 0);
            res.sum      = acc_sum;
            // pad an odd trailing byte with a zero low byte
            if (hi_held)
                res.sum = ones_add(res.sum, {held_hi, 8'h00});
            if (res.sum == 16'h0000)
                res.sum = ulc_pkg::SUM_ALL_ONES;
            expected_sums.push_back(res);
            clear_frame_state();
        end
    endfunction

    initial clear_frame_state();

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            predict_byte(s_frame_byte, s_end_of_frame);
        if (aresetn && s_valid && !s_ready)
            n_input_stalls++;
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("[%0t] checksum mismatch: %s", $time, what);
        n_errors++;
    endtask

    always @(posedge aclk) begin
        csum_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_sums.size() == 0) begin
                report_mismatch($sformatf("result sum=%h short=%b with nothing expected",
                                          m_checksum_sum, m_short_frame));
            end else begin
                want = expected_sums.pop_front();
                n_results++;
                if (want.is_short)
                    n_short_results++;
                if (m_checksum_sum !== want.sum)
                    report_mismatch($sformatf("sum %h, expected %h",
                                              m_checksum_sum, want.sum));
                if (m_short_frame !== want.is_short)
                    report_mismatch($sformatf("short flag %b, expected %b",
                                              m_short_frame, want.is_short));
            end
        end
    end

    // ------------------------------------------------------------------
    // Result consumer: irregular stalls, plus long hold-offs on request
    // ------------------------------------------------------------------
    initial begin
        int          stall_len;
        int          ready_left;
        ready_mode_t ready_mode;
        logic [15:0] ready_bits;
        ready_left = 0;
        ready_mode = RDY_ALWAYS;
        ready_bits = 16'hffff;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_request != 0) begin
                stall_len        = hold_off_request;
                hold_off_request = 0;
                m_ready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end else begin
                if (ready_left == 0) begin
                    ready_mode = ready_mode_t'($urandom_range(0, 3));
                    ready_bits = 16'($urandom) | 16'h0001;
                    ready_left = $urandom_range(20, 200);
                end
                ready_left--;
                case (ready_mode)
                    RDY_ALWAYS: begin
                        m_ready <= 1'b1;
                    end
                    RDY_RANDOM: begin
                        m_ready <= 1'($urandom_range(0, 1));
                    end
                    RDY_MOSTLY: begin
                        m_ready <= ($urandom_range(0, 7) != 0);
                    end
                    default: begin
                        m_ready <= ready_bits[0];
                        ready_bits = {ready_bits[0], ready_bits[15:1]};
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        s_valid        <= 1'b1;
        s_frame_byte   <= value;
        s_end_of_frame <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_bytes_sent++;
        if (gaps_enabled && burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(0, 31);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    function automatic logic [7:0] fill_byte(input fill_t fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hff;
            default:   return 8'($urandom);
        endcase
    endfunction

    // Ethernet header, IPv6 header with the given length and next header,
    // pay_count payload bytes and extra bytes beyond the payload
    function automatic void build_frame(input logic [15:0] len_field, input logic [7:0] nxt,
                                        input int pay_count, input int extra,
                                        input fill_t fill);
        frame_buf.delete();
        for (int i = 0; i < IP_OFF; i++)
            frame_buf.push_back(fill_byte(fill));
        for (int i = 0; i < ulc_pkg::IP_HEADER_BYTES; i++) begin
            if (i == 4)
                frame_buf.push_back(len_field[15:8]);
            else if (i == 5)
                frame_buf.push_back(len_field[7:0]);
            else if (i == 6)
                frame_buf.push_back(nxt);
            else
                frame_buf.push_back(fill_byte(fill));
        end
        for (int i = 0; i < pay_count + extra; i++)
            frame_buf.push_back(fill_byte(fill));
    endfunction

    function automatic void build_noise(input int len);
        frame_buf.delete();
        for (int i = 0; i < len; i++)
            frame_buf.push_back(8'($urandom));
    endfunction

    // send the first n_send bytes of the frame buffer (all when n_send <= 0 or beyond its size)
    task automatic send_frame(input int n_send);
        int n;
        n = (n_send <= 0 || n_send > frame_buf.size()) ? frame_buf.size() : n_send;
        for (int i = 0; i < n; i++)
            send_byte(frame_buf[i], i == n - 1);
        n_frames++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_frames();
        gaps_enabled = 1'b0;
        // runt frames of a single byte at both byte extremes
        build_noise(1);
        frame_buf[0] = 8'h00;
        send_frame(0);
        frame_buf[0] = 8'hff;
        send_frame(0);
        // everything zero: a zero sum must come back as all ones
        build_frame(16'd0, 8'h00, 0, 0, FILL_ZERO);
        send_frame(0);
        // maximum length and next header overflow the seed; payload cut short
        build_frame(16'hffff, 8'hff, 6, 0, FILL_ONES);
        send_frame(0);
        build_frame(16'd20, 8'd6, 20, 0, FILL_RANDOM);
        send_frame(0);
        // odd payload: last byte padded
        build_frame(16'd7, 8'd17, 7, 0, FILL_RANDOM);
        send_frame(0);
        // odd number of payload bytes seen before the frame ends
        build_frame(16'd9, 8'd17, 9, 0, FILL_RANDOM);
        send_frame(PAY_OFF + 5);
        // trailing bytes after the payload are dropped
        build_frame(16'd6, 8'd58, 6, 10, FILL_ONES);
        send_frame(0);
        build_frame(16'd6, 8'd58, 6, 10, FILL_RANDOM);
        send_frame(0);
    endtask

    task automatic test_header_truncation();
        gaps_enabled = 1'b1;
        build_frame(16'd40, 8'd17, 40, 0, FILL_RANDOM);
        send_frame(IP_OFF + 4);
        send_frame(IP_OFF + 5);
        send_frame(IP_OFF + 6);
        send_frame(IP_OFF + 7);
        send_frame(IP_OFF + 9);
        send_frame(PAY_OFF - 1);
        send_frame(PAY_OFF);
        // empty payload: header alone is a complete packet
        build_frame(16'd0, 8'd59, 0, 0, FILL_RANDOM);
        send_frame(0);
    endtask

    task automatic test_frame_length_saturation();
        gaps_enabled = 1'b1;
        // payload counting must carry on once the position counter saturates
        build_frame(16'd2000, 8'd6, 2000, 4, FILL_RANDOM);
        send_frame(0);
    endtask

    task automatic test_result_backpressure();
        gaps_enabled     = 1'b0;
        hold_off_request = 400;
        repeat (60) begin
            build_noise($urandom_range(1, 4));
            send_frame(0);
        end
        build_frame(16'd12, 8'd6, 12, 0, FILL_RANDOM);
        send_frame(0);
    endtask

    task automatic test_random_traffic();
        int          start_bytes;
        int          start_frames;
        int          kind;
        int          plen;
        logic [15:0] len_field;
        start_bytes  = n_bytes_sent;
        start_frames = n_frames;
        while (n_bytes_sent - start_bytes < 300 || n_frames - start_frames < 6) begin
            gaps_enabled = ($urandom_range(0, 9) < 7);
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300)
                                                  : $urandom_range(0, 48);
                build_frame(16'(plen), 8'($urandom), plen,
                            ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0,
                            FILL_RANDOM);
                send_frame(0);
            end else if (kind < 85) begin
                // packet cut at a random length, possibly whole; length field anything at all
                len_field = 16'($urandom);
                plen      = (len_field > 16'd64) ? 64 : int'(len_field);
                build_frame(len_field, 8'($urandom), plen, 0, FILL_RANDOM);
                send_frame($urandom_range(1, frame_buf.size()));
            end else begin
                build_noise($urandom_range(1, 70));
                send_frame(0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_frame_byte   <= 8'h00;
        s_end_of_frame <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_frames();
        test_header_truncation();
        test_frame_length_saturation();
        test_result_backpressure();
        test_random_traffic();

        s_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d bytes in %0d frames, %0d checksums compared (%0d short).",
                 n_bytes_sent, n_frames, n_results, n_short_results);
        $display("Input held off for %0d cycles by back-pressure; %0d mismatches.",
                 n_input_stalls, n_errors);
        if (n_errors == 0)
            $display("** ipv6_upper_layer_checksum_unit: PASSED **");
        else
            $display("** ipv6_upper_layer_checksum_unit: FAILED **");
        $finish;
    end

    initial begin
        #10ms;
        $display("Timed out with %0d results outstanding.", expected_sums.size());
        $display("** ipv6_upper_layer_checksum_unit: FAILED **");
        $finish;
    end

endmodule
